>>> src/trqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package trqd_pkg;

	localparam int SLOT_COUNT = 32;

	typedef enum logic [2:0] {
		OP_SUBMIT   = 3'd0,
		OP_COMPLETE = 3'd1,
		OP_COMMIT   = 3'd2,
		OP_REC_ON   = 3'd3,
		OP_REC_OFF  = 3'd4,
		OP_BUSY_Q   = 3'd5,
		OP_IDLE_Q   = 3'd6,
		OP_UNUSED   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHUTDOWN = 3'd1,
		ST_HALTED   = 3'd2,
		ST_NOMATCH  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	localparam logic [1:0] REG_PACKED = 2'd0;
	localparam logic [1:0] REG_MAXENT = 2'd1;
	localparam logic [1:0] REG_FLUSH  = 2'd2;
	localparam logic [1:0] REG_ENABLE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_PUMP,
		S_EMIT,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> src/tagged_request_queue_dispatcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A word is taken when start is high and busy is low; busy then stays high until the last
// result word of that event has been shown. Results appear for one cycle each, marked by
// result_valid, and the receiver cannot stall them. Configuration words are taken only while
// the block is idle and no word is being started. Events that issue nothing pass through
// the exec, scan, pump and done states. An event that issues tags goes through exec, scan,
// pump and then emit, which shows one result word per tag, as a packed batch reads the tag
// memory one entry a cycle. A slot scan walks one slot a cycle through a shared compare
// until it finds an occupied slot or passes the last one.
module tagged_request_queue_dispatcher_core #(
	parameter int PACKED_DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  op,
	input  wire  [4:0]  req_tag,
	input  wire  [15:0] block_count,
	input  wire         last_hint,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	output logic        result_valid,
	output logic [2:0]  status,
	output logic        issue_valid,
	output logic [4:0]  issue_tag,
	output logic        last,
	output logic        busy_flag,
	output logic        idle_flag,
	output logic        idle_wake
);

	localparam int SW = $clog2(trqd_pkg::SLOT_COUNT + 1);
	localparam int SI = (trqd_pkg::SLOT_COUNT > 2) ? $clog2(trqd_pkg::SLOT_COUNT) : 1;
	localparam int PI = $clog2(PACKED_DEPTH);
	localparam int CW = (PACKED_DEPTH >= 64) ? $clog2(PACKED_DEPTH + 1) : 7;

	trqd_pkg::state_t state_q, state_d;

	logic            packed_q, enable_q;
	logic [5:0]      maxent_q;
	logic [15:0]     flush_q;
	logic [trqd_pkg::SLOT_COUNT-1:0] slot_full_q;
	logic [4:0]      mem_q [PACKED_DEPTH];
	logic [4:0]      rd_s1;
	logic [PI-1:0]   head_q, tail_q;
	logic [CW-1:0]   count_q;
	logic            in_flight_q, batch_busy_q, more_q, halt_q, wait_q;
	logic [SW-1:0]   next_q;
	logic [5:0]      bsize_q;
	logic [5:0]      emit_q;
	logic [SW-1:0]   scan_q;
	logic            do_pump_q, do_scan_q, single_q;

	trqd_pkg::op_t   op_q;
	logic [4:0]      tag_q;
	logic [15:0]     blk_q;
	logic            lh_q;
	logic [2:0]      st_q;
	logic            bflag_q, iflag_q, wake_q;

	logic [5:0]      effmax;
	logic [CW-1:0]   effmax_c;
	logic            pump_ok;

	always_comb begin
		if (maxent_q < 6'd2) effmax = 6'd2;
		else if (maxent_q > 6'd32) effmax = 6'd32;
		else effmax = maxent_q;
	end
	assign effmax_c = CW'(effmax);
	assign pump_ok = !in_flight_q && bsize_q == 6'd0 && count_q != '0 && enable_q &&
		(packed_q || next_q < SW'(trqd_pkg::SLOT_COUNT));

	assign busy = (state_q != trqd_pkg::S_IDLE);
	assign cfg_ready = (state_q == trqd_pkg::S_IDLE) && !start;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trqd_pkg::S_IDLE: if (start) state_d = trqd_pkg::S_EXEC;
			trqd_pkg::S_EXEC: state_d = trqd_pkg::S_SCAN;
			trqd_pkg::S_SCAN: if (!do_scan_q) state_d = trqd_pkg::S_PUMP;
			trqd_pkg::S_PUMP: state_d = (do_pump_q && pump_ok) ? trqd_pkg::S_EMIT
				: trqd_pkg::S_DONE;
			trqd_pkg::S_EMIT: if (emit_q == 6'd1) state_d = trqd_pkg::S_IDLE;
			trqd_pkg::S_DONE: state_d = trqd_pkg::S_IDLE;
			default: state_d = trqd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		result_valid = 1'b0;
		issue_valid  = 1'b0;
		issue_tag    = '0;
		last         = 1'b0;
		unique case (state_q)
			trqd_pkg::S_EMIT: begin
				result_valid = 1'b1;
				issue_valid  = 1'b1;
				issue_tag    = single_q ? 5'(next_q) : rd_s1;
				last         = (emit_q == 6'd1);
			end
			trqd_pkg::S_DONE: begin
				result_valid = 1'b1;
				last         = 1'b1;
			end
			default: ;
		endcase
		status    = st_q;
		busy_flag = bflag_q;
		idle_flag = iflag_q;
		idle_wake = wake_q;
	end

	// Tag memory: written on an accepted submit in packed mode, read one entry a cycle while a batch goes out.
	always_ff @(posedge clk) begin
		if (state_q == trqd_pkg::S_EXEC && op_q == trqd_pkg::OP_SUBMIT && enable_q && !halt_q
			&& packed_q && count_q < CW'(PACKED_DEPTH))
			mem_q[tail_q] <= tag_q;
		rd_s1 <= mem_q[head_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == trqd_pkg::S_IDLE && start) begin
			op_q  <= trqd_pkg::op_t'(op);
			tag_q <= req_tag;
			blk_q <= block_count;
			lh_q  <= last_hint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= trqd_pkg::S_IDLE;
			packed_q     <= 1'b0;
			maxent_q     <= 6'd2;
			flush_q      <= 16'd256;
			enable_q     <= 1'b0;
			slot_full_q  <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			in_flight_q  <= 1'b0;
			batch_busy_q <= 1'b0;
			more_q       <= 1'b0;
			halt_q       <= 1'b0;
			wait_q       <= 1'b0;
			next_q       <= SW'(trqd_pkg::SLOT_COUNT);
			bsize_q      <= '0;
			emit_q       <= '0;
			scan_q       <= '0;
			do_pump_q    <= 1'b0;
			do_scan_q    <= 1'b0;
			single_q     <= 1'b0;
			st_q         <= trqd_pkg::ST_OK;
			bflag_q      <= 1'b0;
			iflag_q      <= 1'b0;
			wake_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					trqd_pkg::REG_PACKED:
						if (count_q == '0 && !in_flight_q && bsize_q == 6'd0)
							packed_q <= cfg_data[0];
					trqd_pkg::REG_MAXENT: maxent_q <= cfg_data[5:0];
					trqd_pkg::REG_FLUSH:  flush_q <= cfg_data;
					trqd_pkg::REG_ENABLE: enable_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				trqd_pkg::S_IDLE: ;
				trqd_pkg::S_EXEC: begin
					st_q      <= trqd_pkg::ST_OK;
					bflag_q   <= 1'b0;
					iflag_q   <= 1'b0;
					wake_q    <= 1'b0;
					do_pump_q <= 1'b0;
					do_scan_q <= 1'b0;
					scan_q    <= '0;
					unique case (op_q)
						trqd_pkg::OP_SUBMIT: begin
							if (!enable_q) st_q <= trqd_pkg::ST_SHUTDOWN;
							else if (halt_q) st_q <= trqd_pkg::ST_HALTED;
							else if (packed_q) begin
								if (count_q >= CW'(PACKED_DEPTH)) st_q <= trqd_pkg::ST_FULL;
								else begin
									tail_q <= (tail_q == PI'(PACKED_DEPTH - 1)) ? '0
										: tail_q + 1'b1;
									count_q <= count_q + 1'b1;
									more_q <= 1'b0;
									do_pump_q <= (blk_q > flush_q) ||
										(count_q + 1'b1 >= effmax_c);
								end
							end else begin
								if (SW'(tag_q) >= SW'(trqd_pkg::SLOT_COUNT) ||
									slot_full_q[SI'(tag_q)])
									st_q <= trqd_pkg::ST_FULL;
								else begin
									slot_full_q[SI'(tag_q)] <= 1'b1;
									count_q <= count_q + 1'b1;
									if (next_q >= SW'(trqd_pkg::SLOT_COUNT))
										next_q <= SW'(tag_q);
									do_pump_q <= 1'b1;
								end
							end
						end
						trqd_pkg::OP_COMPLETE: begin
							if (packed_q) begin
								if (bsize_q == 6'd0) st_q <= trqd_pkg::ST_NOMATCH;
								else begin
									batch_busy_q <= 1'b0;
									bsize_q <= '0;
									if (wait_q && count_q == '0) begin
										wait_q <= 1'b0;
										wake_q <= 1'b1;
									end
									do_pump_q <= !halt_q && ((!more_q && count_q != '0)
										|| count_q >= effmax_c);
								end
							end else begin
								if (!enable_q || !in_flight_q ||
									next_q >= SW'(trqd_pkg::SLOT_COUNT) ||
									next_q != SW'(tag_q))
									st_q <= trqd_pkg::ST_NOMATCH;
								else begin
									slot_full_q[SI'(next_q)] <= 1'b0;
									in_flight_q <= 1'b0;
									if (count_q == '0) next_q <= SW'(trqd_pkg::SLOT_COUNT);
									else if (next_q + 1'b1 < SW'(trqd_pkg::SLOT_COUNT) &&
										slot_full_q[SI'(next_q + 1'b1)])
										next_q <= next_q + 1'b1;
									else do_scan_q <= 1'b1;
									if (wait_q && count_q == '0) begin
										wait_q <= 1'b0;
										wake_q <= 1'b1;
									end
									do_pump_q <= !halt_q && count_q != '0;
								end
							end
						end
						trqd_pkg::OP_COMMIT: begin
							if (packed_q) begin
								if (!lh_q) more_q <= 1'b1;
								else do_pump_q <= 1'b1;
							end
						end
						trqd_pkg::OP_REC_ON: halt_q <= 1'b1;
						trqd_pkg::OP_REC_OFF: begin
							halt_q <= 1'b0;
							do_pump_q <= 1'b1;
						end
						trqd_pkg::OP_BUSY_Q: begin
							if (packed_q) bflag_q <= batch_busy_q && count_q >= effmax_c;
							else bflag_q <= count_q > CW'(1);
						end
						trqd_pkg::OP_IDLE_Q: begin
							logic idl;
							idl = (packed_q ? (bsize_q == 6'd0 && count_q == '0)
								: (!in_flight_q && count_q == '0)) || halt_q;
							iflag_q <= idl;
							wait_q <= !idl;
							st_q <= halt_q ? trqd_pkg::ST_HALTED : trqd_pkg::ST_OK;
						end
						default: ;
					endcase
				end
				trqd_pkg::S_SCAN: begin
					// One slot compared per cycle; the scan ends at the first occupied slot or after the last slot.
					if (do_scan_q) begin
						if (scan_q >= SW'(trqd_pkg::SLOT_COUNT) ||
							slot_full_q[SI'(scan_q)]) begin
							next_q <= scan_q;
							do_scan_q <= 1'b0;
						end else scan_q <= scan_q + 1'b1;
					end
				end
				trqd_pkg::S_PUMP: begin
					if (do_pump_q && pump_ok) begin
						if (packed_q) begin
							logic [CW-1:0] n;
							n = (effmax_c > count_q) ? count_q : effmax_c;
							emit_q <= 6'(n);
							bsize_q <= 6'(n);
							batch_busy_q <= 1'b1;
							count_q <= count_q - n;
							single_q <= 1'b0;
							head_q <= (head_q == PI'(PACKED_DEPTH - 1)) ? '0 : head_q + 1'b1;
						end else begin
							in_flight_q <= 1'b1;
							count_q <= count_q - 1'b1;
							emit_q <= 6'd1;
							single_q <= 1'b1;
						end
					end
				end
				trqd_pkg::S_EMIT: begin
					emit_q <= emit_q - 1'b1;
					if (!single_q && emit_q != 6'd1)
						head_q <= (head_q == PI'(PACKED_DEPTH - 1)) ? '0 : head_q + 1'b1;
				end
				trqd_pkg::S_DONE: ;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sim/tagged_request_queue_dispatcher_core_test.sv
`timescale 1ns / 1ps
module tagged_request_queue_dispatcher_core_test;

	typedef struct {
		trqd_pkg::op_t op;
		logic [4:0]    tag;
		logic [15:0]   blocks;
		logic          lasth;
		bit            aim;
	} event_word_t;

	typedef struct {
		trqd_pkg::status_t st;
		logic       iv;
		logic [4:0] tag;
		logic       lst;
		logic       bf;
		logic       idf;
		logic       wk;
	} result_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  op = '0;
	logic [4:0]  req_tag = '0;
	logic [15:0] block_count = '0;
	logic        last_hint = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	wire         busy, cfg_ready, result_valid, issue_valid, last;
	wire         busy_flag, idle_flag, idle_wake;
	wire  [2:0]  status;
	wire  [4:0]  issue_tag;

	tagged_request_queue_dispatcher_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.req_tag(req_tag), .block_count(block_count), .last_hint(last_hint),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .status(status),
		.issue_valid(issue_valid), .issue_tag(issue_tag), .last(last),
		.busy_flag(busy_flag), .idle_flag(idle_flag), .idle_wake(idle_wake)
	);

	always #6 clk = ~clk;

	// Shadow copy of the dispatcher state and its registers.
	bit          packed_on;
	bit [5:0]    max_ent;
	bit [15:0]   flush_lim;
	bit          q_en;
	bit          slot_full [32];
	bit [4:0]    fifo_mem [64];
	int          head, tail, queued, next_slot, batch_size;
	bit          in_flight, batch_busy, more_coming, halted, waiting_idle, woke;
	logic [4:0]  issued [$];

	event_word_t  pending_words [$];
	result_word_t expected_words [$];
	int  acc_cnt = 0, taken = 0, cfg_cnt = 0, gap = 0, errors = 0, results_seen = 0;
	int  issues_seen = 0;
	bit  idling_on = 1'b1;

	function automatic int eff_max();
		if (max_ent < 2) return 2;
		if (max_ent > 32) return 32;
		return max_ent;
	endfunction

	task automatic dispatch();
		int n;
		if (in_flight || batch_size != 0) return;
		if (queued == 0 || !q_en) return;
		if (packed_on) begin
			n = eff_max();
			if (n > queued) n = queued;
			for (int i = 0; i < n; i++) begin
				issued.push_back(fifo_mem[head]);
				head = (head + 1) % 64;
			end
			batch_size = n;
			batch_busy = 1'b1;
			queued -= n;
		end else begin
			if (next_slot >= 32) return;
			in_flight = 1'b1;
			queued--;
			issued.push_back(next_slot[4:0]);
		end
	endtask

	task automatic retire_done();
		int remains;
		bit need;
		int t;
		remains = queued;
		if (packed_on) begin
			need = !more_coming;
			batch_size = 0;
		end else begin
			need = 1'b1;
			in_flight = 1'b0;
			if (remains == 0)
				next_slot = 32;
			else if (next_slot + 1 < 32 && slot_full[next_slot + 1])
				next_slot++;
			else begin
				for (t = 0; t < 32; t++)
					if (slot_full[t]) break;
				next_slot = t;
			end
		end
		if (waiting_idle && remains == 0) begin
			waiting_idle = 1'b0;
			woke = 1'b1;
		end
		if (halted) return;
		if ((need && remains > 0) || (packed_on && remains >= eff_max()))
			dispatch();
	endtask

	task automatic reset_shadow();
		packed_on = 0; max_ent = 2; flush_lim = 256; q_en = 0;
		foreach (slot_full[i]) slot_full[i] = 0;
		head = 0; tail = 0; queued = 0; next_slot = 32; batch_size = 0;
		in_flight = 0; batch_busy = 0; more_coming = 0; halted = 0; waiting_idle = 0;
	endtask

	task automatic apply_register(logic [1:0] idx, logic [15:0] data);
		case (idx)
			trqd_pkg::REG_PACKED: begin
				if (queued == 0 && !in_flight && batch_size == 0) packed_on = data[0];
			end
			trqd_pkg::REG_MAXENT: max_ent = data[5:0];
			trqd_pkg::REG_FLUSH: flush_lim = data;
			trqd_pkg::REG_ENABLE: q_en = data[0];
			default: ;
		endcase
	endtask

	task automatic predict_results(event_word_t w);
		trqd_pkg::status_t st;
		logic bf, idf;
		result_word_t r;
		int cnt;
		st = trqd_pkg::ST_OK; bf = 0; idf = 0;
		issued.delete();
		woke = 0;
		case (w.op)
			trqd_pkg::OP_SUBMIT: begin
				if (!q_en) st = trqd_pkg::ST_SHUTDOWN;
				else if (halted) st = trqd_pkg::ST_HALTED;
				else if (packed_on) begin
					if (queued >= 64) st = trqd_pkg::ST_FULL;
					else begin
						fifo_mem[tail] = w.tag;
						tail = (tail + 1) % 64;
						queued++;
						more_coming = 0;
						if (w.blocks > flush_lim || queued >= eff_max()) dispatch();
					end
				end else if (slot_full[w.tag]) st = trqd_pkg::ST_FULL;
				else begin
					slot_full[w.tag] = 1;
					queued++;
					if (next_slot >= 32) next_slot = w.tag;
					dispatch();
				end
			end
			trqd_pkg::OP_COMPLETE: begin
				if (packed_on) begin
					if (batch_size == 0) st = trqd_pkg::ST_NOMATCH;
					else begin
						batch_busy = 0;
						retire_done();
					end
				end else if (!q_en || !in_flight || next_slot >= 32 || next_slot != w.tag)
					st = trqd_pkg::ST_NOMATCH;
				else begin
					slot_full[next_slot] = 0;
					retire_done();
				end
			end
			trqd_pkg::OP_COMMIT: begin
				if (packed_on) begin
					if (!w.lasth) more_coming = 1;
					else dispatch();
				end
			end
			trqd_pkg::OP_REC_ON: halted = 1;
			trqd_pkg::OP_REC_OFF: begin
				halted = 0;
				if (queued > 0) dispatch();
			end
			trqd_pkg::OP_BUSY_Q: begin
				if (packed_on) bf = batch_busy && queued >= eff_max();
				else bf = queued > 1;
			end
			trqd_pkg::OP_IDLE_Q: begin
				if (packed_on) idf = (batch_size == 0 && queued == 0) || halted;
				else idf = (!in_flight && queued == 0) || halted;
				st = halted ? trqd_pkg::ST_HALTED : trqd_pkg::ST_OK;
				waiting_idle = !idf;
			end
			default: ;
		endcase
		cnt = issued.size() ? issued.size() : 1;
		for (int k = 0; k < cnt; k++) begin
			r.st = st;
			r.iv = issued.size() != 0;
			r.tag = issued.size() ? issued[k] : 5'd0;
			r.lst = k + 1 == cnt;
			r.bf = bf;
			r.idf = idf;
			r.wk = woke;
			expected_words.push_back(r);
		end
	endtask

	// Words are taken and results checked at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		result_word_t e;
		if (!arst_n) begin
			reset_shadow();
		end else begin
			if (start && !busy) begin
				predict_results('{trqd_pkg::op_t'(op), req_tag, block_count, last_hint, 1'b0});
				acc_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				cfg_cnt++;
			end
			if (result_valid) begin
				results_seen++;
				if (issue_valid) issues_seen++;
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (status !== e.st) begin
						$error("status expected %0d got %0d", e.st, status); errors++;
					end
					if (issue_valid !== e.iv) begin
						$error("issue_valid expected %0d got %0d", e.iv, issue_valid); errors++;
					end
					if (issue_tag !== e.tag) begin
						$error("issue_tag expected %0d got %0d", e.tag, issue_tag); errors++;
					end
					if (last !== e.lst) begin
						$error("last expected %0d got %0d", e.lst, last); errors++;
					end
					if (busy_flag !== e.bf) begin
						$error("busy_flag expected %0d got %0d", e.bf, busy_flag); errors++;
					end
					if (idle_flag !== e.idf) begin
						$error("idle_flag expected %0d got %0d", e.idf, idle_flag); errors++;
					end
					if (idle_wake !== e.wk) begin
						$error("idle_wake expected %0d got %0d", e.wk, idle_wake); errors++;
					end
				end
			end
		end
	end

	// In slot mode, targeted words pick a free slot to submit or the tag in flight to complete.
	always @(negedge clk) begin
		event_word_t w;
		int free_slots [$];
		if (arst_n && (!start || acc_cnt != taken)) begin
			taken = acc_cnt;
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				if (w.aim && !packed_on) begin
					if (w.op == trqd_pkg::OP_COMPLETE && in_flight) w.tag = next_slot[4:0];
					if (w.op == trqd_pkg::OP_SUBMIT) begin
						free_slots.delete();
						foreach (slot_full[i]) if (!slot_full[i]) free_slots.push_back(i);
						if (free_slots.size() != 0)
							w.tag = free_slots[$urandom_range(free_slots.size() - 1)];
					end
				end
				op <= w.op;
				req_tag <= w.tag;
				block_count <= w.blocks;
				last_hint <= w.lasth;
				start <= 1'b1;
				if (idling_on && $urandom_range(3) == 0) gap = $urandom_range(1, 6);
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_word(trqd_pkg::op_t o, int tag, int blocks, bit lasth, bit aim);
		pending_words.push_back('{o, tag[4:0], blocks[15:0], lasth, aim});
	endtask

	task automatic push_random(int n);
		int r, blocks;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			blocks = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300);
			if (r < 40) push_word(trqd_pkg::OP_SUBMIT, $urandom_range(31), blocks,
				1'($urandom_range(1)), 1);
			else if (r < 68) push_word(trqd_pkg::OP_COMPLETE, $urandom_range(31), blocks,
				1'($urandom_range(1)), $urandom_range(9) != 0);
			else if (r < 78) push_word(trqd_pkg::OP_COMMIT, $urandom_range(31), blocks,
				$urandom_range(2) != 0, 0);
			else if (r < 82) push_word(trqd_pkg::OP_REC_ON, $urandom_range(31), blocks, 0, 0);
			else if (r < 88) push_word(trqd_pkg::OP_REC_OFF, $urandom_range(31), blocks, 0, 0);
			else if (r < 93) push_word(trqd_pkg::OP_BUSY_Q, $urandom_range(31), blocks, 0, 0);
			else if (r < 98) push_word(trqd_pkg::OP_IDLE_Q, $urandom_range(31), blocks, 0, 0);
			else push_word(trqd_pkg::OP_UNUSED, $urandom_range(31), blocks,
				1'($urandom_range(1)), 0);
		end
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || start || expected_words.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Empties the queue so that a following mode change takes effect.
	task automatic settle();
		int rounds;
		rounds = 0;
		while ((queued != 0 || in_flight || batch_size != 0) && rounds < 200) begin
			if (in_flight || batch_size != 0) push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
			else push_word(trqd_pkg::OP_REC_OFF, 0, 0, 0, 0);
			while (pending_words.size() != 0 || start || expected_words.size() != 0)
				@(negedge clk);
			rounds++;
		end
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		int c0;
		c0 = cfg_cnt;
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_cnt == c0);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(bit pk, int me, int fl, bit en);
		write_reg(trqd_pkg::REG_PACKED, 16'(pk));
		write_reg(trqd_pkg::REG_MAXENT, 16'(me));
		write_reg(trqd_pkg::REG_FLUSH, 16'(fl));
		write_reg(trqd_pkg::REG_ENABLE, 16'(en));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_word(trqd_pkg::OP_SUBMIT, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_SUBMIT, 31, 65535, 1, 0);
		push_word(trqd_pkg::OP_COMPLETE, 31, 0, 0, 0);
		push_word(trqd_pkg::OP_UNUSED, 31, 65535, 1, 0);
		push_word(trqd_pkg::OP_IDLE_Q, 0, 0, 0, 0);
		drain();
		write_reg(trqd_pkg::REG_ENABLE, 16'd1);
		push_word(trqd_pkg::OP_SUBMIT, 31, 65535, 1, 0);
		push_word(trqd_pkg::OP_SUBMIT, 31, 0, 0, 0);
		push_word(trqd_pkg::OP_SUBMIT, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_SUBMIT, 1, 0, 0, 0);
		push_word(trqd_pkg::OP_BUSY_Q, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_COMPLETE, 5, 0, 0, 0);
		push_word(trqd_pkg::OP_COMMIT, 0, 0, 1, 0);
		push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
		push_word(trqd_pkg::OP_REC_ON, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_IDLE_Q, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_SUBMIT, 7, 0, 0, 0);
		push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
		push_word(trqd_pkg::OP_REC_OFF, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_IDLE_Q, 0, 0, 0, 0);
		push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
		push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
		push_word(trqd_pkg::OP_COMPLETE, 0, 0, 0, 1);
		drain();

		push_random(60);
		drain();
		settle();
		set_all(1, 0, 0, 1);
		push_random(50);
		drain();
		settle();
		set_all(1, 63, 65535, 1);
		push_random(60);
		drain();
		settle();
		set_all(1, 32, 256, 1);
		push_random(45);
		drain();
		settle();
		set_all(0, 33, 100, 1);
		push_random(45);
		drain();
		settle();
		set_all(1, 2, 65535, 1);
		idling_on = 1'b0;
		push_random(50);
		drain();

		$display("Covered slot and packed modes, batch limits 0 to 63, flush bounds 0 and 65535:");
		$display("  %0d words taken, %0d results checked, %0d tags issued.",
			acc_cnt, results_seen, issues_seen);
		if (errors == 0) begin
			$display("tagged_request_queue_dispatcher_core_test passed");
		end else begin
			$display("tagged_request_queue_dispatcher_core_test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tagged_request_queue_dispatcher_core_test failed");
		$finish;
	end

endmodule
